>>> rtl/mfu_pkg.sv
// shared types, constants and the match-word table of the mbox unquote filter
`timescale 1ns / 1ps

package mfu_pkg;

    localparam logic [7:0] QUOTE_CHAR   = 8'h3E;
    localparam logic [7:0] MARK_CHAR    = 8'h01;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;

    localparam int unsigned WORD_LEN  = 5;
    localparam int unsigned MAX_BEATS = 6;
    localparam int unsigned MARK_W    = 17;
    localparam int unsigned HLC_W     = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one input byte's worth of output: [marker] [quote] word[0..word_len-1] [data]
    typedef struct packed {
        logic       marker;
        logic       quote;
        logic [2:0] word_len;
        logic       has_byte;
        logic [7:0] data;
        logic       last;
    } t_burst;

    // letters of "From "
    function automatic logic [7:0] from_letter(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h46;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h6F;
            3'd3:    ch = 8'h6D;
            3'd4:    ch = 8'h20;
            default: ch = 8'h20;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/mfu_front.sv
// front end: line state tracking and classification of each input byte into a burst
`timescale 1ns / 1ps

module mfu_front
    import mfu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_first,
    input  logic             i_last,
    input  logic [HLC_W-1:0] i_hlc,
    output logic             o_ready,
    input  logic             i_queue_ready,
    output logic             o_push,
    output t_burst           o_burst
);

    logic              r_line_start;
    logic [MARK_W-1:0] r_left;
    logic              r_pend;
    logic [2:0]        r_ml;

    logic              n_line_start;
    logic [MARK_W-1:0] n_left;
    logic              n_pend;
    logic [2:0]        n_ml;

    logic              eff_ls;
    logic [MARK_W-1:0] eff_left;
    logic              eff_pend;
    logic [2:0]        eff_ml;
    logic [7:0]        b;
    logic              mark;
    logic              accept;
    t_burst            burst;

    // no byte is taken while reset is held
    assign o_ready = i_queue_ready && i_rst_n;
    assign accept  = i_valid && o_ready;

    always_comb begin
        // a new message restarts the line state and drops anything held
        eff_ls   = i_first ? 1'b1 : r_line_start;
        eff_left = i_first ? ({1'b0, i_hlc} + MARK_W'(1)) : r_left;
        eff_pend = i_first ? 1'b0 : r_pend;
        eff_ml   = i_first ? 3'd0 : r_ml;

        b    = (i_byte == 8'h00) ? SPACE_CHAR : i_byte;
        mark = eff_ls && (eff_left != '0);

        n_left       = mark ? (eff_left - MARK_W'(1)) : eff_left;
        n_line_start = (b == NEWLINE_CHAR);
        n_pend       = eff_pend;
        n_ml         = eff_ml;

        burst          = '0;
        burst.marker   = mark;
        burst.data     = b;
        burst.last     = i_last;

        if (eff_pend) begin
            if (eff_ml == 3'd0 && b == QUOTE_CHAR) begin
                // further quotes pass, the held one stays
                burst.has_byte = 1'b1;
            end else if (b == from_letter(eff_ml)) begin
                if (eff_ml == 3'(WORD_LEN - 1)) begin
                    burst.word_len = 3'(WORD_LEN);
                    n_pend         = 1'b0;
                    n_ml           = 3'd0;
                end else begin
                    n_ml = eff_ml + 3'd1;
                end
            end else begin
                burst.quote    = 1'b1;
                burst.word_len = eff_ml;
                burst.has_byte = 1'b1;
                n_pend         = 1'b0;
                n_ml           = 3'd0;
            end
        end else if (eff_ls && b == QUOTE_CHAR) begin
            n_pend = 1'b1;
            n_ml   = 3'd0;
        end else begin
            burst.has_byte = 1'b1;
        end

        // end of message releases whatever is still held
        if (i_last && n_pend) begin
            burst.quote    = 1'b1;
            burst.word_len = n_ml;
            n_pend         = 1'b0;
            n_ml           = 3'd0;
        end
    end

    assign o_burst = burst;
    assign o_push  = accept && (burst.marker || burst.quote ||
                                burst.word_len != 3'd0 || burst.has_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_start <= 1'b1;
            r_left       <= '0;
            r_pend       <= 1'b0;
            r_ml         <= 3'd0;
        end else if (accept) begin
            r_line_start <= n_line_start;
            r_left       <= n_left;
            r_pend       <= n_pend;
            r_ml         <= n_ml;
        end
    end

endmodule

>>> rtl/mfu_queue.sv
// short burst queue between front end and back end
`timescale 1ns / 1ps

module mfu_queue
    import mfu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_burst i_burst,
    output logic   o_not_full,
    input  logic   i_pop,
    output logic   o_not_empty,
    output t_burst o_head
);

    t_burst              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_not_full  = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (!do_push && do_pop) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

>>> rtl/mfu_back.sv
// back end: expands one burst into output beats behind an output register
`timescale 1ns / 1ps

module mfu_back
    import mfu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_burst     i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data,
    output logic       o_run_end,
    output logic       o_msg_end
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_run_end;
    logic       r_msg_end;
    logic [2:0] r_pos;

    logic [3:0] raw_len;
    logic [3:0] len;
    logic [3:0] pos;
    logic [3:0] p1;
    logic [3:0] p2;
    logic [7:0] beat;
    logic       last_beat;
    logic       load;

    always_comb begin
        raw_len = 4'(i_head.marker) + 4'(i_head.quote) + {1'b0, i_head.word_len}
                + 4'(i_head.has_byte);
        len     = (raw_len > 4'(MAX_BEATS)) ? 4'(MAX_BEATS) : raw_len;
        pos     = {1'b0, r_pos};
        p1      = pos - 4'(i_head.marker);
        p2      = p1 - 4'(i_head.quote);
        if (i_head.marker && pos == 4'd0) begin
            beat = MARK_CHAR;
        end else if (i_head.quote && p1 == 4'd0) begin
            beat = QUOTE_CHAR;
        end else if (p2 < {1'b0, i_head.word_len}) begin
            beat = from_letter(p2[2:0]);
        end else begin
            beat = i_head.data;
        end
        last_beat = (pos == len - 4'd1);
    end

    assign load  = i_head_valid && (!r_valid || i_ready);
    assign o_pop = load && last_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_pos   <= last_beat ? 3'd0 : (r_pos + 3'd1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data    <= beat;
            r_run_end <= last_beat;
            r_msg_end <= last_beat && i_head.last;
        end
    end

    assign o_valid   = r_valid;
    assign o_data    = r_data;
    assign o_run_end = r_run_end;
    assign o_msg_end = r_msg_end;

endmodule

>>> rtl/mbox_from_unquote_filter.sv
// top level of the mbox "From " unquote filter
`timescale 1ns / 1ps
//
// takes the bytes of a stored mail message on the slave stream, one byte a beat,
// and gives the filtered bytes on the master stream, one byte a beat
// input beat: tdata = byte and header line count, tuser = first byte of message,
// tlast = last byte of message (held bytes are flushed with it)
// output beat: tdata = byte, tuser = last beat caused by that input byte,
// tlast = final beat of the message
// each input byte gives 0 to 6 output beats: zero bytes turn into spaces, the
// first header-count-plus-one lines get a 0x01 marker, and ">From " at line start
// loses its first '>' (the quote and partial match are held until decided)
// the first beat of an input byte reaches the master side through the burst queue and
// the output register; the front end takes one byte every cycle while the 4-deep burst
// queue has room, the back end sends one beat a cycle while the receiver is ready, so
// sustained rate is one input byte a cycle when it averages at most one output beat
// reset clears line state, the queue and the output register and holds
// s_axis_tready low; no beat is shown
// when the receiver stalls, the output register holds and the queue fills, then
// s_axis_tready drops until the back end drains a burst
//
module mbox_from_unquote_filter
    import mfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [7:0] in_byte, [23:8] header_line_count
    input  logic        s_axis_tuser,  // [0] first_of_message
    input  logic        s_axis_tlast,  // last_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic        m_axis_tuser,  // [0] run_end
    output logic        m_axis_tlast   // message_end
);

    logic   push;
    logic   pop;
    logic   q_not_full;
    logic   q_not_empty;
    t_burst front_burst;
    t_burst head_burst;

    // front end: classify each byte against the line state
    mfu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .i_byte        (s_axis_tdata[7:0]),
        .i_first       (s_axis_tuser),
        .i_last        (s_axis_tlast),
        .i_hlc         (s_axis_tdata[23:8]),
        .o_ready       (s_axis_tready),
        .i_queue_ready (q_not_full),
        .o_push        (push),
        .o_burst       (front_burst)
    );

    // bursts wait here so both sides stall on their own
    mfu_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_burst     (front_burst),
        .o_not_full  (q_not_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_head      (head_burst)
    );

    // back end: one beat a cycle out of the head burst while the receiver is ready
    mfu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_not_empty),
        .i_head       (head_burst),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_run_end    (m_axis_tuser),
        .o_msg_end    (m_axis_tlast)
    );

endmodule

>>> rtl/mfu_checker.sv
// port-level checks of the mbox unquote filter and their bind
`timescale 1ns / 1ps

module mfu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid right after reset");

    // message end is always the last beat of its input byte
    a_msg_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("message end without run end");

    // zero bytes are replaced, so no output byte is zero
    a_no_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata != 8'h00)
        else $error("zero byte on output");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

endmodule

bind mbox_from_unquote_filter mfu_checker u_mfu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
